FILE: rtl/pfm_pkg.sv
// Package for the pulse flow meter: shared widths, register and action codes,
// and the command, status and result structures. Depends on nothing else.

package pfm_pkg;

    // Default width of the pulse counters.
    localparam int COUNT_WIDTH_DEF = 32;

    // Fixed widths from the field definitions.
    localparam int CFG_IDX_W = 2;
    localparam int CAL_W     = 16;
    localparam int WORD_W    = 32;
    localparam int DEN_W     = WORD_W + CAL_W;   // calibration times elapsed time
    localparam int STEP_W    = 6;

    // Shift-add multiplier and restoring divider step counts.
    localparam int MUL_STEPS = CAL_W;
    localparam int DIV_STEPS = WORD_W;

    // 16000 mL per litre in Q4, and 60000 ms per minute.
    localparam logic [CAL_W-1:0] ML_PER_L_Q4 = 16'd16000;
    localparam logic [CAL_W-1:0] MS_PER_MIN  = 16'd60000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATED   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANOMALY = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CAL_W-1:0]  CAL_RESET     = 16'd7200;
    localparam logic [WORD_W-1:0] RATED_RESET   = 32'd30000;
    localparam logic [WORD_W-1:0] ANOMALY_RESET = 32'd60000;

    // Request actions.
    localparam logic [1:0] ACT_PULSE     = 2'd0;
    localparam logic [1:0] ACT_READ_INT  = 2'd1;
    localparam logic [1:0] ACT_READ_LIFE = 2'd2;
    localparam logic [1:0] ACT_CLR_LIFE  = 2'd3;

    // Result status codes.
    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_NOT_EN  = 3'd1;
    localparam logic [2:0] STS_BAD_INT = 3'd2;
    localparam logic [2:0] STS_BAD_CAL = 3'd3;
    localparam logic [2:0] STS_ANOMALY = 3'd4;
    localparam logic [2:0] STS_OVER    = 3'd5;

    // Operand selection of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_SEL_VOL,
        MUL_SEL_DEN,
        MUL_SEL_FLOW
    } mul_sel_t;

    typedef struct packed {
        logic     accept;
        logic     mul_load;
        logic     mul_step;
        mul_sel_t mul_sel;
        logic     div_load;
        logic     div_step;
        logic     div_flow;
        logic     save_vol;
        logic     save_flow;
        logic     post;
    } pfm_cmd_t;

    typedef struct packed {
        logic has_result;
        logic need_vol;
        logic need_flow;
    } pfm_stat_t;

    typedef struct packed {
        logic              valid_res;
        logic [2:0]        status;
        logic [WORD_W-1:0] pulse_count;
        logic [WORD_W-1:0] volume_ml;
        logic [WORD_W-1:0] flow_ml_per_min;
    } pfm_result_t;

endpackage

FILE: rtl/pulse_flow_meter.sv
// Top level of the pulse flow meter: streaming ports, configuration port and
// the controller and datapath instances. Depends on pfm_pkg, pfm_ctrl, pfm_datapath.
//
// The block counts sensor pulse requests in a wrapping interval counter and a
// wrapping lifetime counter, both COUNT_WIDTH bits wide; pulses only count while
// the sensor is enabled. A read-interval request captures the interval count,
// clears it if the sensor is enabled and the interval nonzero, and reports the
// volume in mL (count*16000/calibration) and the average flow in mL/min
// (count*960000000/(calibration*elapsed_ms)), both truncated and saturated at
// 32 bits, together with a status code for the disabled sensor, a zero interval,
// a zero calibration, an anomaly or a flow above the rated limit. Read-lifetime
// requests report the lifetime count and its volume; pulse and clear-lifetime
// requests give no result. A read-interval request with the full calculation
// computes the volume and then the flow, a lifetime read with a nonzero
// calibration only the volume, and a read that ends on a status flag alone
// goes straight to posting its result. The single shared shift-add multiplier
// takes one multiplier bit per cycle (three products) and the restoring divider
// produces one quotient bit per cycle (two quotients). One request is worked on
// at a time; the result waits in an output register, so a new request is taken
// while the previous result is still waiting to be collected. Configuration
// writes are always taken and are expected only while the block is idle.

module pulse_flow_meter
    import pfm_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    // Request stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [31:0] elapsed_ms
    input  logic [1:0]           s_tuser,   // [1:0] action
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [95:0]          m_tdata,   // [31:0] pulse_count, [63:32] volume_ml,
                                            // [95:64] flow_ml_per_min
    output logic [3:0]           m_tuser    // [0] valid_res, [3:1] status
);

    pfm_cmd_t    cmd;
    pfm_stat_t   stat;
    pfm_result_t result;

    // Registers can always be written.
    assign cfg_ready = 1'b1;

    pfm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfm_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_action  (s_tuser),
        .in_elapsed (s_tdata[WORD_W-1:0]),
        .cmd        (cmd),
        .stat       (stat),
        .result     (result)
    );

    // The result register is packed onto the stream with the count lowest.
    assign m_tdata = {result.flow_ml_per_min, result.volume_ml, result.pulse_count};
    assign m_tuser = {result.status, result.valid_res};

endmodule

FILE: rtl/pfm_ctrl.sv
// Controller of the pulse flow meter: sequences accept, multiply, divide and post.
// Depends on pfm_pkg for the command and status structures.

module pfm_ctrl
    import pfm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  pfm_stat_t stat,
    output pfm_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VMUL,
        ST_VDIV,
        ST_VSAVE,
        ST_DMUL,
        ST_FMUL,
        ST_FDIV,
        ST_FSAVE,
        ST_POST
    } state_t;

    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MUL_STEPS);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              flow_reg, flow_next;
    logic              out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = MUL_SEL_VOL;
        state_next     = state_reg;
        step_next      = step_reg + STEP_W'(1);
        flow_next      = flow_reg;
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    flow_next  = stat.need_flow;
                    if (stat.need_vol)
                    begin
                        state_next = ST_VMUL;
                    end
                    else if (stat.has_result)
                    begin
                        state_next = ST_POST;
                    end
                end
            end
            ST_VMUL, ST_DMUL, ST_FMUL:
            begin
                cmd.mul_sel  = (state_reg == ST_VMUL) ? MUL_SEL_VOL :
                               (state_reg == ST_DMUL) ? MUL_SEL_DEN : MUL_SEL_FLOW;
                cmd.mul_load = (step_reg == '0);
                cmd.mul_step = (step_reg != '0);
                if (step_reg == MUL_LAST)
                begin
                    step_next  = '0;
                    state_next = (state_reg == ST_VMUL) ? ST_VDIV :
                                 (state_reg == ST_DMUL) ? ST_FMUL : ST_FDIV;
                end
            end
            ST_VDIV, ST_FDIV:
            begin
                cmd.div_flow = (state_reg == ST_FDIV);
                cmd.div_load = (step_reg == '0);
                cmd.div_step = (step_reg != '0);
                if (step_reg == DIV_LAST)
                begin
                    step_next  = '0;
                    state_next = (state_reg == ST_VDIV) ? ST_VSAVE : ST_FSAVE;
                end
            end
            ST_VSAVE:
            begin
                cmd.save_vol = 1'b1;
                step_next    = '0;
                state_next   = flow_reg ? ST_DMUL : ST_POST;
            end
            ST_FSAVE:
            begin
                cmd.save_flow = 1'b1;
                step_next     = '0;
                state_next    = ST_POST;
            end
            ST_POST:
            begin
                step_next = '0;
                if (!out_valid_reg || m_tready)
                begin
                    cmd.post       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                step_next  = '0;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            flow_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            flow_reg      <= flow_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/pfm_datapath.sv
// Datapath of the pulse flow meter: registers, counters, shift-add multiplier,
// restoring divider and result registers. Depends on pfm_pkg.

module pfm_datapath
    import pfm_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic [1:0]           in_action,
    input  logic [WORD_W-1:0]    in_elapsed,
    input  pfm_cmd_t             cmd,
    output pfm_stat_t            stat,
    output pfm_result_t          result
);

    // Multiplicand must hold count*16000 as well as the elapsed time.
    localparam int MA_W  = (COUNT_WIDTH + 14 > WORD_W) ? COUNT_WIDTH + 14 : WORD_W;
    localparam int ACC_W = MA_W + CAL_W;
    localparam int NH_W  = ACC_W - WORD_W;

    logic                   enable_reg;
    logic [CAL_W-1:0]       cal_reg;
    logic [WORD_W-1:0]      rated_reg;
    logic [WORD_W-1:0]      anomaly_reg;
    logic [COUNT_WIDTH-1:0] interval_reg;
    logic [COUNT_WIDTH-1:0] lifetime_reg;

    logic [COUNT_WIDTH-1:0] op_cnt_reg;
    logic [WORD_W-1:0]      elapsed_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [MA_W-1:0]        ma_reg;
    logic [CAL_W-1:0]       mb_reg;
    logic [MA_W-1:0]        vnum_reg;
    logic [DEN_W-1:0]       den_reg;
    logic [DEN_W-1:0]       rem_reg;
    logic [WORD_W-1:0]      quo_reg;
    logic [DEN_W-1:0]       dden_reg;
    logic                   over_reg;
    pfm_result_t            res_reg;
    pfm_result_t            out_reg;

    logic                   is_int;
    logic                   is_life;
    logic                   int_ok;
    logic                   cnt_nz;
    logic                   cal_nz;
    logic [MA_W-1:0]        ma_sel;
    logic [CAL_W-1:0]       mb_sel;
    logic [NH_W-1:0]        n_hi;
    logic [DEN_W-1:0]       d_sel;
    logic [DEN_W:0]         r2;
    logic [DEN_W:0]         diff;
    logic                   ge;
    logic [WORD_W-1:0]      div_res;
    logic                   anomaly_hit;
    logic                   rated_hit;
    pfm_result_t            preset;

    assign is_int  = (in_action == ACT_READ_INT);
    assign is_life = (in_action == ACT_READ_LIFE);
    assign int_ok  = enable_reg && (in_elapsed != '0);
    assign cnt_nz  = (interval_reg != '0);
    assign cal_nz  = (cal_reg != '0);

    assign stat.has_result = is_int || is_life;
    assign stat.need_flow  = is_int && int_ok && cnt_nz && cal_nz;
    assign stat.need_vol   = (is_life && cal_nz) || stat.need_flow;

    // Result preset at accept time; volume, flow and limit status follow later.
    always_comb
    begin
        preset                 = '0;
        preset.valid_res       = 1'b1;
        preset.status          = STS_OK;
        if (is_life)
        begin
            preset.pulse_count = WORD_W'(lifetime_reg);
        end
        else if (!enable_reg)
        begin
            preset.valid_res   = 1'b0;
            preset.status      = STS_NOT_EN;
        end
        else if (in_elapsed == '0)
        begin
            preset.valid_res   = 1'b0;
            preset.status      = STS_BAD_INT;
        end
        else if (cnt_nz && !cal_nz)
        begin
            preset.valid_res   = 1'b0;
            preset.status      = STS_BAD_CAL;
            preset.pulse_count = WORD_W'(interval_reg);
        end
        else
        begin
            preset.pulse_count = WORD_W'(interval_reg);
        end
    end

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SEL_VOL:
            begin
                ma_sel = MA_W'(op_cnt_reg);
                mb_sel = ML_PER_L_Q4;
            end
            MUL_SEL_DEN:
            begin
                ma_sel = MA_W'(elapsed_reg);
                mb_sel = cal_reg;
            end
            MUL_SEL_FLOW:
            begin
                ma_sel = vnum_reg;
                mb_sel = MS_PER_MIN;
            end
            default:
            begin
                ma_sel = '0;
                mb_sel = '0;
            end
        endcase
    end

    // The numerator is always the multiplier's product.
    assign n_hi    = acc_reg[ACC_W-1:WORD_W];
    assign d_sel   = cmd.div_flow ? den_reg : DEN_W'(cal_reg);
    assign r2      = {rem_reg, quo_reg[WORD_W-1]};
    assign diff    = r2 - {1'b0, dden_reg};
    assign ge      = (r2 >= {1'b0, dden_reg});
    assign div_res = over_reg ? '1 : quo_reg;

    assign anomaly_hit = (anomaly_reg != '0) && (over_reg || (quo_reg > anomaly_reg));
    assign rated_hit   = (rated_reg != '0) && (over_reg || (quo_reg > rated_reg));

    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            cal_reg      <= CAL_RESET;
            rated_reg    <= RATED_RESET;
            anomaly_reg  <= ANOMALY_RESET;
            interval_reg <= '0;
            lifetime_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ENABLE:  enable_reg  <= cfg_data[0];
                    CFG_CAL:     cal_reg     <= cfg_data[CAL_W-1:0];
                    CFG_RATED:   rated_reg   <= cfg_data;
                    CFG_ANOMALY: anomaly_reg <= cfg_data;
                    default:     enable_reg  <= enable_reg;
                endcase
            end
            if (cmd.accept)
            begin
                case (in_action)
                    ACT_PULSE:
                    begin
                        if (enable_reg)
                        begin
                            interval_reg <= interval_reg + COUNT_WIDTH'(1);
                            lifetime_reg <= lifetime_reg + COUNT_WIDTH'(1);
                        end
                    end
                    ACT_READ_INT:
                    begin
                        if (int_ok)
                        begin
                            interval_reg <= '0;
                        end
                    end
                    ACT_CLR_LIFE: lifetime_reg <= '0;
                    default:      lifetime_reg <= lifetime_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_cnt_reg  <= is_life ? lifetime_reg : interval_reg;
            elapsed_reg <= in_elapsed;
            res_reg     <= preset;
        end
        if (cmd.mul_load)
        begin
            acc_reg <= '0;
            ma_reg  <= ma_sel;
            mb_reg  <= mb_sel;
            if (cmd.mul_sel == MUL_SEL_FLOW)
            begin
                den_reg <= DEN_W'(acc_reg);
            end
        end
        else if (cmd.mul_step)
        begin
            acc_reg <= (acc_reg << 1) + (mb_reg[CAL_W-1] ? ACC_W'(ma_reg) : '0);
            mb_reg  <= mb_reg << 1;
        end
        if (cmd.div_load)
        begin
            // Quotient of 2^32 or more shows up as high part >= divisor.
            over_reg <= (DEN_W'(n_hi) >= d_sel);
            rem_reg  <= DEN_W'(n_hi);
            quo_reg  <= acc_reg[WORD_W-1:0];
            dden_reg <= d_sel;
            if (!cmd.div_flow)
            begin
                vnum_reg <= MA_W'(acc_reg);
            end
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
            quo_reg <= {quo_reg[WORD_W-2:0], ge};
        end
        if (cmd.save_vol)
        begin
            res_reg.volume_ml <= div_res;
        end
        if (cmd.save_flow)
        begin
            res_reg.flow_ml_per_min <= div_res;
            if (anomaly_hit)
            begin
                res_reg.valid_res <= 1'b0;
                res_reg.status    <= STS_ANOMALY;
            end
            else if (rated_hit)
            begin
                res_reg.status    <= STS_OVER;
            end
        end
        if (cmd.post)
        begin
            out_reg <= res_reg;
        end
    end

endmodule

FILE: verif/pfm_checker.sv
// Result checker for the pulse flow meter: follows the configuration, request and
// result channels, predicts every reading and compares it field by field.
// Depends on pfm_pkg for the action, status and register codes and the result type.

module pfm_checker
    import pfm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [31:0] elapsed_ms
    input  logic [1:0]           s_tuser,   // [1:0] action
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [95:0]          m_tdata,   // [31:0] pulse_count, [63:32] volume_ml,
                                            // [95:64] flow_ml_per_min
    input  logic [3:0]           m_tuser,   // [0] valid_res, [3:1] status
    output int                   fail_count,
    output int                   pending
);

    localparam logic [95:0] ML_SCALE   = 96'd16000;       // mL per litre in Q4
    localparam logic [95:0] FLOW_SCALE = 96'd960000000;   // 60000 ms/min times 16000

    logic              sensor_on;
    logic [CAL_W-1:0]  cal_q4;
    logic [WORD_W-1:0] rated_limit;
    logic [WORD_W-1:0] anomaly_limit;
    logic [WORD_W-1:0] interval_pulses;
    logic [WORD_W-1:0] lifetime_pulses;
    pfm_result_t       readings_due[$];
    int                mismatches;

    function automatic logic [WORD_W-1:0] clip_word(input logic [95:0] value);
        return (value > 96'hFFFF_FFFF) ? '1 : value[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] volume_of(input logic [WORD_W-1:0] pulses,
                                                    input logic [CAL_W-1:0] cal);
        logic [95:0] num;
        logic [95:0] den;
        num = 96'(pulses);
        den = 96'(cal);
        return clip_word((num * ML_SCALE) / den);
    endfunction

    // Advances the model by one accepted request and queues the reading it causes.
    task automatic take_request(input logic [1:0] action, input logic [WORD_W-1:0] elapsed);
        pfm_result_t reading;
        logic [95:0] num;
        logic [95:0] den;
        logic [95:0] flow;
        logic        has_reading;
        reading     = '0;
        has_reading = 1'b1;
        case (action)
            ACT_PULSE:
            begin
                has_reading = 1'b0;
                if (sensor_on)
                begin
                    interval_pulses = interval_pulses + WORD_W'(1);
                    lifetime_pulses = lifetime_pulses + WORD_W'(1);
                end
            end
            ACT_CLR_LIFE:
            begin
                has_reading     = 1'b0;
                lifetime_pulses = '0;
            end
            ACT_READ_LIFE:
            begin
                reading.valid_res   = 1'b1;
                reading.status      = STS_OK;
                reading.pulse_count = lifetime_pulses;
                if (cal_q4 != '0)
                    reading.volume_ml = volume_of(lifetime_pulses, cal_q4);
            end
            default:
            begin
                if (!sensor_on)
                    reading.status = STS_NOT_EN;
                else if (elapsed == '0)
                    reading.status = STS_BAD_INT;
                else
                begin
                    reading.pulse_count = interval_pulses;
                    interval_pulses     = '0;
                    if (reading.pulse_count == '0)
                        reading.valid_res = 1'b1;
                    else if (cal_q4 == '0)
                        reading.status = STS_BAD_CAL;
                    else
                    begin
                        reading.volume_ml = volume_of(reading.pulse_count, cal_q4);
                        num  = 96'(reading.pulse_count);
                        den  = 96'(cal_q4);
                        den  = den * 96'(elapsed);
                        flow = (num * FLOW_SCALE) / den;
                        reading.flow_ml_per_min = clip_word(flow);
                        // The limits are compared with the exact, unclipped flow.
                        if (anomaly_limit != '0 && flow > 96'(anomaly_limit))
                            reading.status = STS_ANOMALY;
                        else if (rated_limit != '0 && flow > 96'(rated_limit))
                        begin
                            reading.valid_res = 1'b1;
                            reading.status    = STS_OVER;
                        end
                        else
                        begin
                            reading.valid_res = 1'b1;
                            reading.status    = STS_OK;
                        end
                    end
                end
            end
        endcase
        if (has_reading)
            readings_due.push_back(reading);
    endtask

    task automatic check_field(input string what, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_on       = 1'b0;
            cal_q4          = CAL_RESET;
            rated_limit     = RATED_RESET;
            anomaly_limit   = ANOMALY_RESET;
            interval_pulses = '0;
            lifetime_pulses = '0;
            mismatches      = 0;
            readings_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ENABLE:  sensor_on     = cfg_data[0];
                    CFG_CAL:     cal_q4        = cfg_data[CAL_W-1:0];
                    CFG_RATED:   rated_limit   = cfg_data;
                    CFG_ANOMALY: anomaly_limit = cfg_data;
                    default:     ;
                endcase
            end
            if (s_tvalid && s_tready)
                take_request(s_tuser, s_tdata[WORD_W-1:0]);
            if (m_tvalid && m_tready)
            begin
                if (readings_due.size() == 0)
                begin
                    $display("%0t: unexpected reading: expected none, actual %0h/%0h",
                             $time, m_tuser, m_tdata);
                    mismatches++;
                end
                else
                begin
                    check_field("valid_res", WORD_W'(readings_due[0].valid_res),
                                WORD_W'(m_tuser[0]));
                    check_field("status", WORD_W'(readings_due[0].status),
                                WORD_W'(m_tuser[3:1]));
                    check_field("pulse_count", readings_due[0].pulse_count, m_tdata[31:0]);
                    check_field("volume_ml", readings_due[0].volume_ml, m_tdata[63:32]);
                    check_field("flow_ml_per_min", readings_due[0].flow_ml_per_min,
                                m_tdata[95:64]);
                    void'(readings_due.pop_front());
                end
            end
        end
        fail_count <= mismatches;
        pending    <= readings_due.size();
    end

endmodule

FILE: verif/tb_top.sv
// Top of the pulse flow meter testbench: clock, reset, request and configuration
// stimulus, result back-pressure and the final verdict.
// Depends on pfm_pkg, pulse_flow_meter and pfm_checker.

module tb_top;
    import pfm_pkg::*;

    // Roughly this many requests are sent, spread over the configuration phases.
    localparam int ITEM_TARGET   = 1300;
    localparam int NUM_PHASES    = 12;
    // This comfortably covers any request that is still being worked on when the
    // last reading has come out.
    localparam int SETTLE_CYCLES = 150;
    // Length of the long back-pressure stretch on the result side.
    localparam int HOLD_CYCLES   = 600;
    localparam int HOLD_PHASE    = 3;
    // The phase in which neither side idles at all.
    localparam int CALM_PHASE    = 6;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;   // [31:0] elapsed_ms
    logic [1:0]           s_tuser   = '0;   // [1:0] action
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [95:0]          m_tdata;          // [31:0] pulse_count, [63:32] volume_ml,
                                            // [95:64] flow_ml_per_min
    logic [3:0]           m_tuser;          // [0] valid_res, [3:1] status

    int fail_count;
    int pending;
    int sent      = 0;
    int hold_left = 0;
    bit idle_on   = 1'b1;
    bit hold_req  = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    pulse_flow_meter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    pfm_checker reading_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Result side. Normally it refuses about a quarter of the cycles at random. When
    // the stimulus asks for it, it refuses for a long stretch so that the output
    // register fills, the block stalls and the request side is held back.
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (idle_on)
            m_tready <= ($urandom_range(0, 99) >= 25);
        else
            m_tready <= 1'b1;
    end

    // Watchdog: a stuck handshake or a reading that never arrives ends the run here.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    // One register write. The valid is left high so that back-to-back writes do not
    // lower and raise it in the same step; the caller lowers it after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [WORD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Writes every register; called only while the block is idle.
    task automatic write_settings(input logic enable, input logic [CAL_W-1:0] cal,
                                  input logic [WORD_W-1:0] rated,
                                  input logic [WORD_W-1:0] anomaly);
        write_reg(CFG_ENABLE, {31'd0, enable});
        write_reg(CFG_CAL, {16'd0, cal});
        write_reg(CFG_RATED, rated);
        write_reg(CFG_ANOMALY, anomaly);
        cfg_valid <= 1'b0;
    endtask

    // Offers one request and waits until it is taken. While idling is on, a gap is left
    // before about a quarter of the requests; otherwise the valid simply stays high.
    task automatic send_req(input logic [1:0] action, input logic [WORD_W-1:0] elapsed);
        if (idle_on && $urandom_range(0, 99) < 25)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= elapsed;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    // Stops the request stream and waits until every reading is in and the block
    // has had time to finish any pulse or clear request still in hand.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Interval lengths: mostly short ones that give flows near the limits, with zero,
    // the largest value and the full 32-bit range mixed in.
    function automatic logic [WORD_W-1:0] pick_elapsed();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return $urandom;
            3:       return $urandom_range(1, 20);
            4:       return '1;
            default: return $urandom_range(1, 5000);
        endcase
    endfunction

    function automatic logic [CAL_W-1:0] pick_cal();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'd1;
            2:       return '1;
            3:       return CAL_W'($urandom_range(0, 65535));
            default: return CAL_W'($urandom_range(16, 8000));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            default: return $urandom_range(10, 50000);
        endcase
    endfunction

    // Mostly a burst of pulses closed by an interval read; the rest lifetime reads,
    // lifetime clears and single requests of any kind with random content.
    task automatic send_group();
        int kind;
        int pulses;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            pulses = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                 : $urandom_range(0, 12);
            repeat (pulses) send_req(ACT_PULSE, $urandom);
            send_req(ACT_READ_INT, pick_elapsed());
        end
        else if (kind < 80)
            send_req(ACT_READ_LIFE, $urandom);
        else if (kind < 85)
            send_req(ACT_CLR_LIFE, $urandom);
        else
            send_req(2'($urandom_range(0, 3)), $urandom);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight after reset the sensor is off: interval reads are refused and
        // pulses are dropped, while the lifetime read still answers.
        send_req(ACT_READ_INT, 32'd1000);
        send_req(ACT_PULSE, '1);
        send_req(ACT_READ_LIFE, '0);
        drain();

        // Sensor on with the reset calibration: a zero interval keeps the count, an
        // empty interval reads as valid zero, and the lifetime count can be cleared.
        write_settings(1'b1, CAL_RESET, RATED_RESET, ANOMALY_RESET);
        send_req(ACT_READ_INT, '0);
        send_req(ACT_READ_INT, 32'd1000);
        repeat (3) send_req(ACT_PULSE, '0);
        send_req(ACT_READ_INT, '0);
        send_req(ACT_READ_INT, '1);
        send_req(ACT_READ_LIFE, '0);
        send_req(ACT_CLR_LIFE, '1);
        send_req(ACT_READ_LIFE, '0);
        drain();

        // Zero calibration: a nonzero count is flagged and the lifetime volume is zero.
        write_settings(1'b1, '0, RATED_RESET, ANOMALY_RESET);
        repeat (2) send_req(ACT_PULSE, '0);
        send_req(ACT_READ_INT, 32'd500);
        send_req(ACT_READ_LIFE, '0);
        drain();

        // Smallest calibration and a one-millisecond interval: first a flow above the
        // rated limit, then one that overflows 32 bits and trips the anomaly limit.
        write_settings(1'b1, 16'd1, 32'd100, '1);
        send_req(ACT_PULSE, '0);
        send_req(ACT_READ_INT, 32'd1);
        repeat (5) send_req(ACT_PULSE, '0);
        send_req(ACT_READ_INT, 32'd1);
        drain();

        // Largest calibration with both limits switched off.
        write_settings(1'b1, '1, '0, '0);
        repeat (2) send_req(ACT_PULSE, '0);
        send_req(ACT_READ_INT, 32'd1);

        sent = 0;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            case (phase)
                0:       write_settings(1'b1, '1, '1, '1);
                1:       write_settings(1'b1, 16'd1, '0, '0);
                default: write_settings($urandom_range(0, 9) != 0, pick_cal(),
                                        pick_limit(), pick_limit());
            endcase
            idle_on = (phase != CALM_PHASE);
            if (phase == HOLD_PHASE)
                hold_req = 1'b1;
            while (sent < (phase + 1) * ITEM_TARGET / NUM_PHASES)
                send_group();
        end
        drain();

        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
